// File: design/gcke_pkg.sv
package gcke_pkg;

  localparam int GRID_SIDE = 128;
  localparam int ROW_W     = $clog2(GRID_SIDE);
  localparam int ADDR_W    = 2 * ROW_W;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int MEM_W     = 32 + 48 + 32;

  localparam int DIV_STEPS = 16;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  localparam logic [47:0] VAR_RESET = 48'd42949672960000;
  localparam logic [31:0] Q_RESET   = 32'd43;
  localparam logic [47:0] R_RESET   = 48'd429496730;

  typedef enum logic {
    CFG_PROCESS_NOISE = 1'b0,
    CFG_MEAS_NOISE    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MS_Q_DLO  = 3'd0,
    MS_Q_DHI  = 3'd1,
    MS_K_D    = 3'd2,
    MS_PP_C   = 3'd3,
    MS_TMP_C  = 3'd4,
    MS_R_K    = 3'd5,
    MS_TMP_K  = 3'd6
  } mul_sel_t;

  typedef struct packed {
    logic              take;
    logic              clear;
    logic [ADDR_W-1:0] clear_addr;
    logic              load_cell;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic              grow_lo;
    logic              psum;
    logic              den;
    logic              div_init;
    logic              div_step;
    logic              elev;
    logic              rnd;
    logic              a_done;
    logic              fin;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic pp_ge_den;
    logic out_free;
  } stat_t;

endpackage

// File: design/grid_cell_kalman_elevation_update_top.sv
// Scalar Kalman elevation update over a 128 x 128 grid of cells. After reset the
// block clears all 16384 cells of its memory (one cell a cycle) and takes no item
// meanwhile; configuration writes are taken at any time. The time an item takes
// is set by the 16-step restoring divider for the gain, skipped when the gain
// saturates or the denominator is zero, and by the single shared 48 x 17 multiplier
// that serves all seven products in turn. The controller returns to idle as the
// result is registered, and the next item is taken from there. One item is worked
// on at a time; a finished result waits in an output register while the next item
// is accepted, and the update stalls before its write-back while that register is
// still full.
module grid_cell_kalman_elevation_update_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [6:0]         cell_row,
  input  logic [6:0]         cell_col,
  input  logic signed [31:0] measured_height,
  input  logic [31:0]        time_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_row,
  output logic [6:0]         out_col,
  output logic signed [31:0] new_elevation,
  output logic [47:0]        new_variance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [47:0]        cfg_data
);
  import gcke_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  gcke_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcke_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cell_row        (cell_row),
    .cell_col        (cell_col),
    .measured_height (measured_height),
    .time_ms         (time_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_col         (out_col),
    .new_elevation   (new_elevation),
    .new_variance    (new_variance)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

// File: design/gcke_ctrl.sv
module gcke_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gcke_pkg::stat_t stat,
  output gcke_pkg::cmd_t  cmd
);
  import gcke_pkg::*;

  typedef enum logic [16:0] {
    S_CLEAR  = 17'b1 << 0,
    S_IDLE   = 17'b1 << 1,
    S_READ   = 17'b1 << 2,
    S_GLO    = 17'b1 << 3,
    S_GHI    = 17'b1 << 4,
    S_PSUM   = 17'b1 << 5,
    S_DEN    = 17'b1 << 6,
    S_DCHK   = 17'b1 << 7,
    S_DIV    = 17'b1 << 8,
    S_MUL_E  = 17'b1 << 9,
    S_ELEV   = 17'b1 << 10,
    S_RND_A1 = 17'b1 << 11,
    S_MUL_A2 = 17'b1 << 12,
    S_A_DONE = 17'b1 << 13,
    S_RND_B1 = 17'b1 << 14,
    S_MUL_B2 = 17'b1 << 15,
    S_FIN    = 17'b1 << 16
  } state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_cnt;
  logic [CNT_W-1:0]  div_cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = MS_Q_DLO;
    cmd.clear_addr = clr_cnt;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (clr_cnt == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        cmd.load_cell = 1'b1;
        state_next = S_GLO;
      end
      S_GLO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_Q_DLO;
        state_next = S_GHI;
      end
      S_GHI: begin
        cmd.grow_lo = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_Q_DHI;
        state_next = S_PSUM;
      end
      S_PSUM: begin
        cmd.psum = 1'b1;
        state_next = S_DEN;
      end
      S_DEN: begin
        cmd.den = 1'b1;
        state_next = S_DCHK;
      end
      S_DCHK: begin
        cmd.div_init = 1'b1;
        // zero denominator or saturated gain needs no division
        if (stat.den_zero || stat.pp_ge_den) state_next = S_MUL_E;
        else state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_LAST) state_next = S_MUL_E;
      end
      S_MUL_E: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_K_D;
        state_next = S_ELEV;
      end
      S_ELEV: begin
        cmd.elev = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_PP_C;
        state_next = S_RND_A1;
      end
      S_RND_A1: begin
        cmd.rnd = 1'b1;
        state_next = S_MUL_A2;
      end
      S_MUL_A2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_TMP_C;
        state_next = S_A_DONE;
      end
      S_A_DONE: begin
        cmd.a_done = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_R_K;
        state_next = S_RND_B1;
      end
      S_RND_B1: begin
        cmd.rnd = 1'b1;
        state_next = S_MUL_B2;
      end
      S_MUL_B2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_TMP_K;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        cmd.fin = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_DIV) div_cnt <= div_cnt + 1'b1;
      else div_cnt <= '0;
    end
  end

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt != DIV_LAST) |=> (state == S_DIV))
    else $error("divider left early");

  a_clear_first: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && clr_cnt != '1) |=> (state == S_CLEAR))
    else $error("clearing pass cut short");

endmodule

// File: design/gcke_dp.sv
module gcke_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  gcke_pkg::cmd_t            cmd,
  output gcke_pkg::stat_t           stat,
  input  logic                      cfg_valid,
  input  logic                      cfg_index,
  input  logic [47:0]               cfg_data,
  input  logic [6:0]                cell_row,
  input  logic [6:0]                cell_col,
  input  logic signed [31:0]        measured_height,
  input  logic [31:0]               time_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [6:0]                out_row,
  output logic [6:0]                out_col,
  output logic signed [31:0]        new_elevation,
  output logic [47:0]               new_variance
);
  import gcke_pkg::*;

  logic [MEM_W-1:0] mem [CELLS];
  logic [MEM_W-1:0] rdata;
  logic [MEM_W-1:0] wdata;
  logic [ADDR_W-1:0] waddr;
  logic             we;

  logic [31:0] q;
  logic [47:0] r;
  logic [ROW_W-1:0] row_q, col_q;
  logic signed [31:0] z, x;
  logic [31:0] t, dt;
  logic [47:0] p, acc, pp, tmp, a;
  logic [48:0] den, rem;
  logic [15:0] k;
  logic signed [31:0] e;
  logic [64:0] prod;

  logic [47:0] ma;
  logic [16:0] mb;
  logic [16:0] c;
  logic signed [32:0] d;
  logic        dneg;
  logic [32:0] dmag;
  logic [31:0] last;
  logic [63:0] grow;
  logic [48:0] psum;
  logic [49:0] rem2;
  logic signed [66:0] sv, sw;
  logic [48:0] pn;
  logic [47:0] rnd_prod;
  logic [65:0] rsum;

  assign c = 17'd65536 - {1'b0, k};
  assign d = {z[31], z} - {x[31], x};
  assign dneg = d[32];
  assign dmag = dneg ? (33'd0 - d) : d;
  assign last = rdata[111:80];

  always_comb begin
    case (cmd.mul_sel)
      MS_Q_DLO: begin ma = {16'b0, q}; mb = {1'b0, dt[15:0]}; end
      MS_Q_DHI: begin ma = {16'b0, q}; mb = {1'b0, dt[31:16]}; end
      MS_K_D:   begin ma = {15'b0, dmag}; mb = {1'b0, k}; end
      MS_PP_C:  begin ma = pp; mb = c; end
      MS_TMP_C: begin ma = tmp; mb = c; end
      MS_R_K:   begin ma = r; mb = {1'b0, k}; end
      MS_TMP_K: begin ma = tmp; mb = {1'b0, k}; end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  // round half up, then drop 16 fraction bits
  assign rsum = {1'b0, prod} + 66'd32768;
  assign rnd_prod = rsum[63:16];

  assign grow = {16'b0, acc} + {prod[47:0], 16'b0};
  assign psum = {1'b0, p} + {1'b0, grow[47:0]};
  assign rem2 = {rem, 1'b0};
  assign sv = dneg ? (67'sd0 - $signed({2'b0, prod})) : $signed({2'b0, prod});
  assign sw = (sv + 67'sd32768) >>> 16;
  assign pn = {1'b0, a} + {1'b0, rnd_prod};

  assign stat.den_zero  = (den == '0);
  assign stat.pp_ge_den = ({1'b0, pp} >= den);
  assign stat.out_free  = !out_valid || out_ready;

  assign we    = cmd.clear || cmd.fin;
  assign waddr = cmd.clear ? cmd.clear_addr : {row_q, col_q};
  assign wdata = cmd.clear ? {32'b0, VAR_RESET, 32'b0}
                           : {t, (pn[48] ? 48'hFFFF_FFFF_FFFF : pn[47:0]), e};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.take) rdata <= mem[{cell_row[ROW_W-1:0], cell_col[ROW_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= Q_RESET;
      r <= R_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_idx_t'(cfg_index) == CFG_PROCESS_NOISE) q <= cfg_data[31:0];
        else r <= cfg_data;
      end
      if (cmd.fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_q <= cell_row[ROW_W-1:0];
      col_q <= cell_col[ROW_W-1:0];
      z     <= measured_height;
      t     <= time_ms;
    end
    if (cmd.load_cell) begin
      x  <= rdata[31:0];
      p  <= rdata[79:32];
      dt <= (t >= last) ? (t - last) : 32'd0;
    end
    if (cmd.mul_en) prod <= ma * mb;
    if (cmd.grow_lo) acc <= prod[47:0];
    if (cmd.psum) begin
      if (grow[63:48] != '0 || psum[48]) pp <= '1;
      else pp <= psum[47:0];
    end
    if (cmd.den) den <= {1'b0, r} + {1'b0, pp};
    if (cmd.div_init) begin
      rem <= {1'b0, pp};
      k   <= (!stat.den_zero && stat.pp_ge_den) ? 16'hFFFF : 16'd0;
    end
    if (cmd.div_step) begin
      if (rem2 >= {1'b0, den}) begin
        rem <= 49'(rem2 - {1'b0, den});
        k   <= {k[14:0], 1'b1};
      end else begin
        rem <= rem2[48:0];
        k   <= {k[14:0], 1'b0};
      end
    end
    if (cmd.elev) e <= x + sw[31:0];
    if (cmd.rnd) tmp <= rnd_prod;
    if (cmd.a_done) a <= rnd_prod;
    if (cmd.fin) begin
      out_row       <= 7'(row_q);
      out_col       <= 7'(col_q);
      new_elevation <= e;
      new_variance  <= pn[48] ? 48'hFFFF_FFFF_FFFF : pn[47:0];
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.fin))
    else $error("result shown without a finished update");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !$past(cmd.fin))
    else $error("pending result overwritten");

endmodule

// File: sim/tb_grid_cell_kalman_elevation_update_top.sv
module tb_grid_cell_kalman_elevation_update_top;
  import gcke_pkg::*;

  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 240;

  typedef struct packed {
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] elev;
    logic [47:0]        var_q;
  } cell_result_t;

  typedef struct packed {
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] height;
    logic [31:0]        t_ms;
    logic               fixed_elev;
    logic signed [31:0] elev;
  } probe_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [6:0]         cell_row = '0;
  logic [6:0]         cell_col = '0;
  logic signed [31:0] measured_height = '0;
  logic [31:0]        time_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [6:0]         out_row;
  logic [6:0]         out_col;
  logic signed [31:0] new_elevation;
  logic [47:0]        new_variance;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = CFG_PROCESS_NOISE;
  logic [47:0]        cfg_data = '0;

  grid_cell_kalman_elevation_update_top uut (.*);

  always #6 clk = ~clk;

  logic signed [31:0] elev_est [CELLS];
  logic [47:0]        var_est [CELLS];
  logic [31:0]        last_ms [CELLS];
  logic [31:0]        q_per_ms;
  logic [47:0]        r_noise;

  cell_result_t pending_updates[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_start = 1'b0;
  int  hold_left = 0;

  function automatic logic [63:0] rnd16(logic [63:0] v);
    return (v + 64'd32768) >> 16;
  endfunction

  function automatic cell_result_t kalman_update(logic [6:0] row, logic [6:0] col,
                                                 logic signed [31:0] z, logic [31:0] t);
    logic [13:0] idx;
    longint x, e;
    logic [63:0] p, dt, grow, pp, den, k, c, a, b, pn;
    cell_result_t res;
    idx = {row, col};
    x = elev_est[idx];
    p = var_est[idx];
    dt = (t >= last_ms[idx]) ? 64'(t - last_ms[idx]) : 64'd0;
    grow = 64'(q_per_ms) * dt;
    if (grow > MASK48 || p + grow > MASK48) pp = MASK48;
    else pp = p + grow;
    den = 64'(r_noise) + pp;
    if (den == 0) k = 0;
    else begin
      k = (pp << 16) / den;
      if (k > 64'd65535) k = 64'd65535;
    end
    // ties toward +inf is a plain floor of (v + half)
    e = x + (((longint'(k) * (longint'(z) - x)) + 64'sd32768) >>> 16);
    c = 64'd65536 - k;
    a = rnd16(rnd16(pp * c) * c);
    b = rnd16(rnd16(64'(r_noise) * k) * k);
    pn = a + b;
    if (pn > MASK48) pn = MASK48;
    elev_est[idx] = e[31:0];
    var_est[idx] = pn[47:0];
    last_ms[idx] = t;
    res.row = row;
    res.col = col;
    res.elev = e[31:0];
    res.var_q = pn[47:0];
    return res;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PROCESS_NOISE) q_per_ms = value[31:0];
    else r_noise = value;
  endtask

  task automatic send_item(logic [6:0] row, logic [6:0] col, logic signed [31:0] z,
                           logic [31:0] t, bit fixed_elev, logic signed [31:0] elev);
    cell_result_t res;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    cell_row        <= row;
    cell_col        <= col;
    measured_height <= z;
    time_ms         <= t;
    do @(posedge clk); while (!in_ready);
    res = kalman_update(row, col, z, t);
    if (fixed_elev) res.elev = elev;
    pending_updates = {pending_updates, res};
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin
    cell_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item r%0d c%0d", out_row, out_col);
      end else begin
        exp_r = pending_updates.pop_front();
        if (exp_r.row !== out_row || exp_r.col !== out_col ||
            exp_r.elev !== new_elevation || exp_r.var_q !== new_variance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp r%0d c%0d e%0d v%0d, got r%0d c%0d e%0d v%0d",
                     exp_r.row, exp_r.col, exp_r.elev, exp_r.var_q,
                     out_row, out_col, new_elevation, new_variance);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  probe_t probes [16] = '{
    '{7'd0,   7'd0,   32'sd0,         32'd0,          1'b1, 32'sd0},
    '{7'd127, 7'd127, 32'sh7FFFFFFF,  32'd0,          1'b0, 32'sd0},
    '{7'd127, 7'd0,   32'sh80000000,  32'd1,          1'b0, 32'sd0},
    '{7'd0,   7'd127, -32'sd1,        32'd100,        1'b0, 32'sd0},
    '{7'd127, 7'd127, 32'sh80000000,  32'd5,          1'b0, 32'sd0},
    '{7'd127, 7'd127, 32'sh7FFFFFFF,  32'd6,          1'b0, 32'sd0},
    '{7'd5,   7'd5,   32'sd65536,     32'd1000,       1'b0, 32'sd0},
    '{7'd5,   7'd5,   32'sd131072,    32'd500,        1'b0, 32'sd0},
    '{7'd5,   7'd5,   -32'sd65536,    32'hFFFFFFFF,   1'b0, 32'sd0},
    '{7'd5,   7'd5,   32'sd0,         32'd0,          1'b0, 32'sd0},
    '{7'd64,  7'd64,  32'sd12345,     32'd77,         1'b0, 32'sd0},
    '{7'd64,  7'd64,  32'sd12345,     32'd77,         1'b0, 32'sd0},
    '{7'd64,  7'd64,  32'sd12345,     32'd77,         1'b0, 32'sd0},
    '{7'd85,  7'd42,  32'sh55555555,  32'hAAAAAAAA,   1'b0, 32'sd0},
    '{7'd42,  7'd85,  32'shAAAAAAAA,  32'h55555555,   1'b0, 32'sd0},
    '{7'd1,   7'd1,   32'sd0,         32'd0,          1'b1, 32'sd0}
  };

  initial begin
    logic [31:0] q_set [PHASES];
    logic [47:0] r_set [PHASES];
    logic [13:0] pool [8];
    logic [31:0] cur_t;
    logic [31:0] t;
    logic [6:0]  row, col;
    logic signed [31:0] z;
    int sel;
    for (int i = 0; i < CELLS; i++) begin
      elev_est[i] = '0;
      var_est[i] = VAR_RESET;
      last_ms[i] = '0;
    end
    q_per_ms = Q_RESET;
    r_noise = R_RESET;
    q_set = '{Q_RESET, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, $urandom, $urandom_range(0, 5000)};
    r_set = '{R_RESET, 48'd1, 48'hFFFF_FFFF_FFFF, 48'd1,
              48'({$urandom, $urandom} & MASK48),
              48'(64'd1 << $urandom_range(0, 47))};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    cur_t = 32'd1000;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_PROCESS_NOISE, 48'(q_set[ph]));
      write_reg(CFG_MEAS_NOISE, r_set[ph]);
      quiet = (ph == 2);
      if (ph == 0)
        foreach (probes[i])
          send_item(probes[i].row, probes[i].col, probes[i].height, probes[i].t_ms,
                    probes[i].fixed_elev, probes[i].elev);
      foreach (pool[i]) pool[i] = 14'($urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == 50) hold_start = 1'b1;
        if (ph == 3 && n == 100) begin
          in_valid <= 1'b0;
          while (pending_updates.size() != 0) @(posedge clk);
        end
        sel = $urandom_range(0, 99);
        {row, col} = pool[$urandom_range(0, 7)];
        if (sel < 80) begin
          cur_t = cur_t + $urandom_range(0, 3000);
          t = cur_t;
        end else if (sel < 90) begin
          row = 7'($urandom);
          col = 7'($urandom);
          t = $urandom;
        end else begin
          t = cur_t - $urandom_range(1, 500);
        end
        if ($urandom_range(0, 99) < 20) z = $urandom;
        else z = 32'sd655360 + $signed(32'($urandom_range(0, 131072))) - 32'sd65536;
        send_item(row, col, z, t, 1'b0, 32'sd0);
      end
      drain();
    end
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
